// ===== hdl/grf_pkg.sv =====
// shared types, constants and the quarter-wave sine table for the ray fan block
// no dependencies; grf_cmd_if, grf_ctrl, grf_dp and the top level import this package
package grf_pkg;

    // grid and ray configuration
    localparam int GRID_W    = 32;
    localparam int GRID_H    = 32;
    localparam int RAY_COUNT = 160;
    localparam int FRAC_BITS = 8;

    // fixed field widths
    localparam int FUNC_W   = 2;
    localparam int CELL_IN_W = 5;
    localparam int FLAGS_W  = 4;
    localparam int ORIG_W   = 13;
    localparam int FACING_W = 2;
    localparam int STEP_SIZE_W = 8;
    localparam logic [STEP_SIZE_W-1:0] STEP_SIZE_RST = 8'd128;

    // derived widths
    localparam int CX_W      = $clog2(GRID_W);
    localparam int CY_W      = $clog2(GRID_H);
    localparam int ADDR_W    = CX_W + CY_W;
    localparam int CELL_DEPTH = 1 << ADDR_W;
    localparam int GRID_BITS = (CX_W > CY_W) ? CX_W : CY_W;
    localparam int POS_BASE  = (ORIG_W > GRID_BITS + FRAC_BITS) ? ORIG_W : GRID_BITS + FRAC_BITS;
    localparam int POS_W     = ((POS_BASE > 9) ? POS_BASE : 9) + 2;
    localparam int CELL_W    = POS_W - FRAC_BITS;
    localparam int R_W       = $clog2(RAY_COUNT + 1);
    localparam int K_W       = $clog2(RAY_COUNT);
    localparam int SIN_W     = 15;
    localparam int TRIG_W    = SIN_W + 1;
    localparam int PROD_W    = TRIG_W + STEP_SIZE_W + 1;
    localparam int STEP_W    = 10;
    localparam int TRIG_FRAC = 14;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_WALL = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CAST = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RSVD = 2'd3;

    // wall flag bit positions
    localparam int WALL_E = 0;
    localparam int WALL_S = 1;
    localparam int WALL_W = 2;
    localparam int WALL_N = 3;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [CELL_IN_W-1:0] cell_x;
        logic [CELL_IN_W-1:0] cell_y;
        logic [FLAGS_W-1:0]   wall_flags;
        logic [ORIG_W-1:0]    origin_x;
        logic [ORIG_W-1:0]    origin_y;
        logic [FACING_W-1:0]  facing;
    } t_item;

    typedef struct packed {
        logic latch;
        logic clr_en;
        logic clr_walls;
        logic clr_rst;
        logic wall_wr;
        logic vis_cap;
        logic ray_init;
        logic ray_setup;
        logic step_rd;
        logic step_adv;
        logic ray_next;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic clr_last;
        logic ray_last;
        logic cur_in;
        logic stop;
        logic out_free;
    } t_sts;

    typedef logic [SIN_W-1:0] t_sin_tab [0:RAY_COUNT];

    // round(sin(pi/2 * r / RAY_COUNT) * 2^14), taylor series in q30
    function automatic logic [SIN_W-1:0] f_qsin(input int unsigned r);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] res;
        bit          neg;
        x    = (HALF_PI_Q30 * 64'(r)) / 64'(RAY_COUNT);
        term = x;
        sum  = x;
        neg  = 1'b1;
        for (int n = 3; n <= 17; n += 2) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (n)
                3:       term = term / 64'd6;
                5:       term = term / 64'd20;
                7:       term = term / 64'd42;
                9:       term = term / 64'd72;
                11:      term = term / 64'd110;
                13:      term = term / 64'd156;
                15:      term = term / 64'd210;
                default: term = term / 64'd272;
            endcase
            if (neg) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
            neg = !neg;
        end
        res = (sum + 64'd32768) >> 16;
        if (r == 0) begin
            res = 64'd0;
        end
        return res[SIN_W-1:0];
    endfunction

    function automatic t_sin_tab f_build_sin();
        t_sin_tab t;
        for (int i = 0; i <= RAY_COUNT; i++) begin
            t[i] = f_qsin(i);
        end
        return t;
    endfunction

    localparam t_sin_tab SIN_TAB = f_build_sin();

endpackage

// ===== hdl/grf_cmd_if.sv =====
// command channel: valid/ready plus one input word
// depends on grf_pkg for field widths
interface grf_cmd_if import grf_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [CELL_IN_W-1:0] cell_x;
    logic [CELL_IN_W-1:0] cell_y;
    logic [FLAGS_W-1:0]   wall_flags;
    logic [ORIG_W-1:0]    origin_x;
    logic [ORIG_W-1:0]    origin_y;
    logic [FACING_W-1:0]  facing;

    modport source (output valid, func, cell_x, cell_y, wall_flags, origin_x, origin_y, facing,
                    input ready);
    modport sink (input valid, func, cell_x, cell_y, wall_flags, origin_x, origin_y, facing,
                  output ready);
endinterface

// ===== hdl/grf_res_if.sv =====
// result channel: valid/ready plus the visible bit
// no package dependency
interface grf_res_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink (input valid, visible, output ready);
endinterface

// ===== hdl/grid_ray_fan_visibility.sv =====
// top level of the ray fan visibility block: controller, datapath, assertions
// depends on grf_pkg, grf_cmd_if, grf_res_if, grf_ctrl, grf_dp
//
//  port         dir  handshake     word
//  i_cmd        in   valid/ready   func, cell_x, cell_y, wall_flags, origin_x, origin_y, facing
//  o_res        out  valid/ready   visible
//  i_cfg_*      in   write enable  step_size
//
// one item at a time; wall write and unused code pass S_DEC then S_RESP, read adds S_RDW
// a cast clears the bitmap, then per ray sets up in S_RAY and marches in steps of
// a wall ram read (S_STEP_RD) then an evaluate (S_STEP_EV)
// after reset a clear pass sweeps both rams; i_cmd.ready stays low
// the result register lets a new word in while the last result is unread
module grid_ray_fan_visibility import grf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    grf_cmd_if.sink                i_cmd,
    grf_res_if.source              o_res,
    input  logic                   i_cfg_we,
    input  logic [STEP_SIZE_W-1:0] i_cfg_wdata
);
    t_cmd  s_cmd;
    t_sts  s_sts;
    t_item item;

    assign item.func       = i_cmd.func;
    assign item.cell_x     = i_cmd.cell_x;
    assign item.cell_y     = i_cmd.cell_y;
    assign item.wall_flags = i_cmd.wall_flags;
    assign item.origin_x   = i_cmd.origin_x;
    assign item.origin_y   = i_cmd.origin_y;
    assign item.facing     = i_cmd.facing;

    grf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    grf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (s_cmd),
        .o_sts         (s_sts),
        .i_item        (item),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_out_visible (o_res.visible)
    );

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.clr_en |-> !i_cmd.ready)
        else $error("word accepted during clear pass");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.out_load |-> s_sts.out_free)
        else $error("pending result overwritten");

    a_load_shows_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.out_load |=> o_res.valid)
        else $error("result load lost");
endmodule

// ===== hdl/grf_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module grf_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/grf_ctrl.sv =====
// sequencer for clear passes, wall writes, reads, ray setup, march steps and result hand-off
// depends on grf_pkg (t_cmd, t_sts, func codes)
module grf_ctrl import grf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [7:0] {
        S_CLR     = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_DEC     = 8'b0000_0100,
        S_RDW     = 8'b0000_1000,
        S_RAY     = 8'b0001_0000,
        S_STEP_RD = 8'b0010_0000,
        S_STEP_EV = 8'b0100_0000,
        S_RESP    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_clr_walls, n_clr_walls;
    t_cmd   cmd;

    always_comb begin
        n_state     = r_state;
        n_clr_walls = r_clr_walls;
        cmd         = '0;
        cmd.clr_walls = r_clr_walls;
        case (r_state)
            S_CLR: begin
                cmd.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_clr_walls = 1'b0;
                    n_state     = r_clr_walls ? S_IDLE : S_RAY;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.latch = 1'b1;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                case (i_sts.func)
                    FUNC_WALL: begin
                        cmd.wall_wr = 1'b1;
                        n_state     = S_RESP;
                    end
                    FUNC_CAST: begin
                        cmd.ray_init = 1'b1;
                        cmd.clr_rst  = 1'b1;
                        n_state      = S_CLR;
                    end
                    FUNC_READ: n_state = S_RDW;
                    default:   n_state = S_RESP;
                endcase
            end
            S_RDW: begin
                cmd.vis_cap = 1'b1;
                n_state     = S_RESP;
            end
            S_RAY: begin
                cmd.ray_setup = 1'b1;
                n_state       = S_STEP_RD;
            end
            S_STEP_RD: begin
                if (i_sts.cur_in) begin
                    cmd.step_rd = 1'b1;
                    n_state     = S_STEP_EV;
                end else if (i_sts.ray_last) begin
                    n_state = S_RESP;
                end else begin
                    cmd.ray_next = 1'b1;
                    n_state      = S_RAY;
                end
            end
            S_STEP_EV: begin
                if (!i_sts.stop) begin
                    cmd.step_adv = 1'b1;
                    n_state      = S_STEP_RD;
                end else if (i_sts.ray_last) begin
                    n_state = S_RESP;
                end else begin
                    cmd.ray_next = 1'b1;
                    n_state      = S_RAY;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_walls <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_clr_walls <= n_clr_walls;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;
endmodule

// ===== hdl/grf_dp.sv =====
// datapath: step register, wall and visibility rams, angle counters, ray position
// depends on grf_pkg and grf_ram
module grf_dp import grf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  t_item                  i_item,
    input  logic                   i_cfg_we,
    input  logic [STEP_SIZE_W-1:0] i_cfg_wdata,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_out_visible
);
    t_item                    r_item;
    logic [STEP_SIZE_W-1:0]   r_step;
    logic [ADDR_W-1:0]        r_clr_addr;
    logic [1:0]               r_q;
    logic [R_W-1:0]           r_r;
    logic [K_W-1:0]           r_k;
    logic signed [STEP_W-1:0] r_sx, r_sy;
    logic signed [POS_W-1:0]  r_px, r_py;
    logic                     r_hit;
    logic                     r_out_valid, r_out_vis;

    // item cell
    logic              item_in;
    logic [ADDR_W-1:0] item_addr;
    assign item_in   = (int'(r_item.cell_x) < GRID_W) && (int'(r_item.cell_y) < GRID_H);
    assign item_addr = {CY_W'(r_item.cell_y), CX_W'(r_item.cell_x)};

    // sine and cosine from the quarter table
    logic [1:0]                cq;
    logic [R_W-1:0]            sin_idx, cos_idx;
    logic signed [TRIG_W-1:0]  sin_val, cos_val;
    logic [STEP_SIZE_W-1:0]    st;
    logic signed [STEP_SIZE_W:0] st_s;
    logic signed [PROD_W-1:0]  prod_x, prod_y;
    logic signed [PROD_W-1:0]  rnd_x, rnd_y;

    assign cq      = r_q + 2'd1;
    assign sin_idx = r_q[0] ? R_W'(RAY_COUNT) - r_r : r_r;
    assign cos_idx = cq[0] ? R_W'(RAY_COUNT) - r_r : r_r;
    assign sin_val = r_q[1] ? -$signed({1'b0, SIN_TAB[sin_idx]}) : $signed({1'b0, SIN_TAB[sin_idx]});
    assign cos_val = cq[1] ? -$signed({1'b0, SIN_TAB[cos_idx]}) : $signed({1'b0, SIN_TAB[cos_idx]});
    // zero step acts as one
    assign st      = (r_step == '0) ? STEP_SIZE_W'(1) : r_step;
    assign st_s    = $signed({1'b0, st});
    assign prod_x  = cos_val * st_s;
    assign prod_y  = sin_val * st_s;
    assign rnd_x   = prod_x + PROD_W'(1 << (TRIG_FRAC - 1));
    assign rnd_y   = prod_y + PROD_W'(1 << (TRIG_FRAC - 1));

    // ray angle advance by two units, wrapping the quadrant
    logic [R_W:0] r_sum;
    assign r_sum = {1'b0, r_r} + (R_W+1)'(2);

    // current and next cell
    logic signed [POS_W-1:0]  nxt_px, nxt_py;
    logic signed [CELL_W-1:0] ox, oy, nx, ny;
    logic signed [CELL_W:0]   dx, dy;
    logic                     cur_in, nxt_in, stop;
    logic [ADDR_W-1:0]        cur_addr;
    logic [FLAGS_W-1:0]       wall;

    assign nxt_px = r_px + POS_W'(r_sx);
    assign nxt_py = r_py + POS_W'(r_sy);
    assign ox     = r_px[POS_W-1:FRAC_BITS];
    assign oy     = r_py[POS_W-1:FRAC_BITS];
    assign nx     = nxt_px[POS_W-1:FRAC_BITS];
    assign ny     = nxt_py[POS_W-1:FRAC_BITS];
    assign dx     = {nx[CELL_W-1], nx} - {ox[CELL_W-1], ox};
    assign dy     = {ny[CELL_W-1], ny} - {oy[CELL_W-1], oy};
    assign cur_in = !ox[CELL_W-1] && !oy[CELL_W-1] && (int'(ox) < GRID_W) && (int'(oy) < GRID_H);
    assign nxt_in = !nx[CELL_W-1] && !ny[CELL_W-1] && (int'(nx) < GRID_W) && (int'(ny) < GRID_H);
    assign cur_addr = {CY_W'(oy), CX_W'(ox)};

    always_comb begin
        stop = !nxt_in;
        if (dx == '0) begin
            if ((dy == -1 && wall[WALL_N]) || (dy == 1 && wall[WALL_S])) begin
                stop = 1'b1;
            end
        end
        if (dy == '0) begin
            if ((dx == -1 && wall[WALL_W]) || (dx == 1 && wall[WALL_E])) begin
                stop = 1'b1;
            end
        end
        // diagonal move into another cell
        if (dx != '0 && dy != '0) begin
            stop = 1'b1;
        end
    end

    // memories
    logic              wall_we, vis_we, vis_rdata;
    logic [ADDR_W-1:0] wall_waddr, vis_waddr;
    logic [FLAGS_W-1:0] wall_wdata;

    assign wall_we    = (i_cmd.clr_en && i_cmd.clr_walls) || (i_cmd.wall_wr && item_in);
    assign wall_waddr = i_cmd.clr_en ? r_clr_addr : item_addr;
    assign wall_wdata = i_cmd.clr_en ? '0 : r_item.wall_flags;
    assign vis_we     = i_cmd.clr_en || (i_cmd.step_rd && cur_in);
    assign vis_waddr  = i_cmd.clr_en ? r_clr_addr : cur_addr;

    grf_ram #(.WIDTH(FLAGS_W), .DEPTH(CELL_DEPTH)) u_wall_ram (
        .i_clk   (i_clk),
        .i_we    (wall_we),
        .i_waddr (wall_waddr),
        .i_wdata (wall_wdata),
        .i_raddr (cur_addr),
        .o_rdata (wall)
    );

    grf_ram #(.WIDTH(1), .DEPTH(CELL_DEPTH)) u_vis_ram (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (!i_cmd.clr_en),
        .i_raddr (item_addr),
        .o_rdata (vis_rdata)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        if (i_cmd.latch) begin
            r_hit <= 1'b0;
        end else if (i_cmd.vis_cap) begin
            r_hit <= vis_rdata && item_in;
        end
        if (i_cmd.ray_init) begin
            r_q <= r_item.facing + 2'd3;
            r_r <= '0;
        end else if (i_cmd.ray_next) begin
            if (int'(r_sum) >= RAY_COUNT) begin
                r_r <= R_W'(r_sum - (R_W+1)'(RAY_COUNT));
                r_q <= r_q + 2'd1;
            end else begin
                r_r <= r_sum[R_W-1:0];
            end
        end
        if (i_cmd.ray_init) begin
            r_k <= '0;
        end else if (i_cmd.ray_next) begin
            r_k <= r_k + K_W'(1);
        end
        if (i_cmd.ray_setup) begin
            r_sx <= STEP_W'(rnd_x >>> TRIG_FRAC);
            r_sy <= STEP_W'(rnd_y >>> TRIG_FRAC);
            r_px <= POS_W'(r_item.origin_x);
            r_py <= POS_W'(r_item.origin_y);
        end else if (i_cmd.step_adv) begin
            r_px <= nxt_px;
            r_py <= nxt_py;
        end
        if (i_cmd.out_load) begin
            r_out_vis <= r_hit;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_SIZE_RST;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
            if (i_cmd.clr_rst) begin
                r_clr_addr <= '0;
            end else if (i_cmd.clr_en) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.func     = r_item.func;
        o_sts.clr_last = (r_clr_addr == '1);
        o_sts.ray_last = (r_k == K_W'(RAY_COUNT - 1));
        o_sts.cur_in   = cur_in;
        o_sts.stop     = stop;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_visible = r_out_vis;
endmodule
